### hdl/dpld_pkg.sv
// shared types, constants and register codes for the dual pid drive core
package dpld_pkg;

  // default fraction bits of the gains, integrators and pid sums
  localparam int DEF_GAIN_FRAC_BITS = 8;

  localparam int FAST_SPEED_TARGET = 40;
  localparam int SLOW_SPEED_TARGET = 10;
  localparam int FAST_DERIV_SCALE  = 50;
  localparam int STEER_INT_TOP     = 300;
  localparam int SPEED_INT_TOP     = 1000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // widths of the gain products and of the pid sums
  localparam int PROD_W = 36;
  localparam int SUM_W  = 40;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KI    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KD    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE   = 3'd7;

  typedef struct packed {
    logic        [6:0]  line_position;
    logic signed [15:0] left_encoder_count;
    logic signed [15:0] right_encoder_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0] left_motor_drive;
    logic [15:0] right_motor_drive;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  line_target;
    logic [15:0] steer_kp;
    logic [15:0] steer_ki;
    logic [15:0] steer_kd;
    logic [15:0] speed_kp;
    logic [15:0] speed_ki;
    logic [15:0] speed_kd;
    logic        fast_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    line_target: 7'd64,
    steer_kp:    16'd6400,
    steer_ki:    16'd0,
    steer_kd:    16'd12800,
    speed_kp:    16'd7680,
    speed_ki:    16'd51,
    speed_kd:    16'd12800,
    fast_mode:   1'b1
  };

  typedef struct packed {
    logic signed [PROD_W-1:0] steer_p;
    logic signed [PROD_W-1:0] steer_i;
    logic signed [PROD_W-1:0] steer_d;
    logic signed [PROD_W-1:0] speed_p;
    logic signed [PROD_W-1:0] speed_i;
    logic signed [PROD_W-1:0] speed_d;
  } prod_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] steer_sum;
    logic signed [SUM_W-1:0] speed_sum;
  } sum_t;

endpackage

### hdl/dpld_err_mul.sv
// error terms, per-mode previous errors and the gain products
module dpld_err_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dpld_pkg::in_item_t item_i,
  input  dpld_pkg::cfg_t   cfg_i,
  output dpld_pkg::prod_t  prod_o
);

  logic signed [7:0]  prev_se_q [2];
  logic signed [17:0] prev_ve_q [2];
  dpld_pkg::prod_t    prod_q;

  logic               mode;
  logic signed [7:0]  se;
  logic signed [8:0]  sd_raw;
  logic signed [14:0] sd_x50;
  logic signed [14:0] sd;
  logic signed [16:0] meas;
  logic signed [16:0] meas_adj;
  logic signed [16:0] meas_half;
  logic signed [16:0] meas_sel;
  logic signed [17:0] spd_tgt;
  logic signed [17:0] ve;
  logic signed [18:0] vd;
  logic signed [16:0] steer_kp_s, steer_ki_s, steer_kd_s;
  logic signed [16:0] speed_kp_s, speed_ki_s, speed_kd_s;
  logic signed [24:0] steer_p_w, steer_i_w;
  logic signed [31:0] steer_d_w;
  logic signed [34:0] speed_p_w, speed_i_w;
  logic signed [35:0] speed_d_w;

  assign mode = cfg_i.fast_mode;

  // steering error and derivative
  assign se     = signed'({1'b0, item_i.line_position}) - signed'({1'b0, cfg_i.line_target});
  assign sd_raw = {se[7], se} - {prev_se_q[mode][7], prev_se_q[mode]};
  assign sd_x50 = {{6{sd_raw[8]}}, sd_raw} * signed'(15'(dpld_pkg::FAST_DERIV_SCALE));
  assign sd     = mode ? sd_x50 : {{6{sd_raw[8]}}, sd_raw};

  // measured speed, halved toward zero in slow mode
  assign meas      = {item_i.left_encoder_count[15], item_i.left_encoder_count}
                   + {item_i.right_encoder_count[15], item_i.right_encoder_count};
  assign meas_adj  = meas + signed'({16'b0, meas[16]});
  assign meas_half = meas_adj >>> 1;
  assign meas_sel  = mode ? meas : meas_half;

  assign spd_tgt = mode ? signed'(18'(dpld_pkg::FAST_SPEED_TARGET))
                        : signed'(18'(dpld_pkg::SLOW_SPEED_TARGET));
  assign ve      = spd_tgt - {meas_sel[16], meas_sel};
  assign vd      = {ve[17], ve} - {prev_ve_q[mode][17], prev_ve_q[mode]};

  assign steer_kp_s = signed'({1'b0, cfg_i.steer_kp});
  assign steer_ki_s = signed'({1'b0, cfg_i.steer_ki});
  assign steer_kd_s = signed'({1'b0, cfg_i.steer_kd});
  assign speed_kp_s = signed'({1'b0, cfg_i.speed_kp});
  assign speed_ki_s = signed'({1'b0, cfg_i.speed_ki});
  assign speed_kd_s = signed'({1'b0, cfg_i.speed_kd});

  assign steer_p_w = steer_kp_s * se;
  assign steer_i_w = steer_ki_s * se;
  assign steer_d_w = steer_kd_s * sd;
  assign speed_p_w = speed_kp_s * ve;
  assign speed_i_w = speed_ki_s * ve;
  assign speed_d_w = speed_kd_s * vd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_se_q[0] <= '0;
      prev_se_q[1] <= '0;
      prev_ve_q[0] <= '0;
      prev_ve_q[1] <= '0;
    end else if (en_i) begin
      prev_se_q[mode] <= se;
      prev_ve_q[mode] <= ve;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q.steer_p <= dpld_pkg::PROD_W'(steer_p_w);
      prod_q.steer_i <= dpld_pkg::PROD_W'(steer_i_w);
      prod_q.steer_d <= dpld_pkg::PROD_W'(steer_d_w);
      prod_q.speed_p <= dpld_pkg::PROD_W'(speed_p_w);
      prod_q.speed_i <= dpld_pkg::PROD_W'(speed_i_w);
      prod_q.speed_d <= dpld_pkg::PROD_W'(speed_d_w);
    end
  end

  assign prod_o = prod_q;

endmodule

### hdl/dpld_integ.sv
// clamped integrators and the steering and speed pid sums
module dpld_integ #(
  parameter int GAIN_FRAC_BITS = dpld_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  dpld_pkg::prod_t prod_i,
  output dpld_pkg::sum_t  sums_o
);

  localparam int IW = dpld_pkg::PROD_W + 1;
  localparam logic signed [IW-1:0] STEER_TOP =
    IW'(dpld_pkg::STEER_INT_TOP * (1 << GAIN_FRAC_BITS));
  localparam logic signed [IW-1:0] SPEED_TOP =
    IW'(dpld_pkg::SPEED_INT_TOP * (1 << GAIN_FRAC_BITS));
  localparam logic signed [IW-1:0] ACC_MIN = {{(IW-31){1'b1}}, 31'b0};

  function automatic logic signed [31:0] clamp_acc(
    input logic signed [IW-1:0] s,
    input logic signed [IW-1:0] top
  );
    logic signed [IW-1:0] r;
    if (s > top) r = top;
    else if (s < ACC_MIN) r = ACC_MIN;
    else r = s;
    return r[31:0];
  endfunction

  logic signed [31:0] steer_acc_q, speed_acc_q;
  logic signed [31:0] steer_acc_d, speed_acc_d;
  logic signed [IW-1:0] steer_raw, speed_raw;
  dpld_pkg::sum_t sums_q;

  assign steer_raw = IW'(steer_acc_q) + IW'(prod_i.steer_i);
  assign speed_raw = IW'(speed_acc_q) + IW'(prod_i.speed_i);
  assign steer_acc_d = clamp_acc(steer_raw, STEER_TOP);
  assign speed_acc_d = clamp_acc(speed_raw, SPEED_TOP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_acc_q <= '0;
      speed_acc_q <= '0;
    end else if (en_i) begin
      steer_acc_q <= steer_acc_d;
      speed_acc_q <= speed_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sums_q.steer_sum <= dpld_pkg::SUM_W'(prod_i.steer_p) + dpld_pkg::SUM_W'(prod_i.steer_d)
                        + dpld_pkg::SUM_W'(steer_acc_d);
      sums_q.speed_sum <= dpld_pkg::SUM_W'(prod_i.speed_p) + dpld_pkg::SUM_W'(prod_i.speed_d)
                        + dpld_pkg::SUM_W'(speed_acc_d);
    end
  end

  assign sums_o = sums_q;

endmodule

### hdl/dpld_motor.sv
// motor mix, truncation and saturation into the result register
module dpld_motor #(
  parameter int GAIN_FRAC_BITS = dpld_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  dpld_pkg::sum_t      sums_i,
  output dpld_pkg::out_item_t drive_o
);

  localparam int MW = dpld_pkg::SUM_W + 1;

  function automatic logic [15:0] to_motor(input logic signed [MW-1:0] v);
    logic [15:0] r;
    if (v[MW-1]) r = '0;
    else if (|v[MW-2:GAIN_FRAC_BITS+16]) r = '1;
    else r = v[GAIN_FRAC_BITS+15:GAIN_FRAC_BITS];
    return r;
  endfunction

  logic signed [MW-1:0] mix_add, mix_sub;
  dpld_pkg::out_item_t  drive_q;

  assign mix_add = MW'(sums_i.speed_sum) + MW'(sums_i.steer_sum);
  assign mix_sub = MW'(sums_i.speed_sum) - MW'(sums_i.steer_sum);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q.left_motor_drive  <= to_motor(mix_add);
      drive_q.right_motor_drive <= to_motor(mix_sub);
    end
  end

  assign drive_o = drive_q;

endmodule

### hdl/dual_pid_line_follow_drive_core.sv
// line-following differential drive controller: steering pid and speed pid per control tick
//
// one transfer in gives one transfer out, through the input register, gain product register,
// integrator and pid sum register, then the result register. a new tick can be taken every
// cycle unless a stall has backed up to the input register. the two integrators close their
// loop through a combinational add and clamp and the per-mode previous errors update as a
// tick leaves the input register, so back-to-back ticks see the state of the tick before.
// every stage holds while the one after it is full and stalled, so ticks keep flowing into
// empty stages while a finished result waits. write the registers only while no tick is
// in flight; fast_mode chooses the speed target, the measured speed and the steering
// derivative scale, and each mode keeps its own previous errors.
module dual_pid_line_follow_drive_core #(
  parameter int GAIN_FRAC_BITS = dpld_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [dpld_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dpld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // control tick in
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dpld_pkg::in_item_t                  in_data_i,
  // motor drives out
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dpld_pkg::out_item_t                 out_data_o
);

  dpld_pkg::cfg_t      cfg_q;
  dpld_pkg::in_item_t  in_q;
  logic                a_valid_q, b_valid_q, c_valid_q, o_valid_q;
  logic                adv_o, adv_c, adv_b, adv_a;
  dpld_pkg::prod_t     prod;
  dpld_pkg::sum_t      sums;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dpld_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpld_pkg::REG_LINE_TARGET: cfg_q.line_target <= cfg_data_i[6:0];
        dpld_pkg::REG_STEER_KP:    cfg_q.steer_kp    <= cfg_data_i;
        dpld_pkg::REG_STEER_KI:    cfg_q.steer_ki    <= cfg_data_i;
        dpld_pkg::REG_STEER_KD:    cfg_q.steer_kd    <= cfg_data_i;
        dpld_pkg::REG_SPEED_KP:    cfg_q.speed_kp    <= cfg_data_i;
        dpld_pkg::REG_SPEED_KI:    cfg_q.speed_ki    <= cfg_data_i;
        dpld_pkg::REG_SPEED_KD:    cfg_q.speed_kd    <= cfg_data_i;
        dpld_pkg::REG_FAST_MODE:   cfg_q.fast_mode   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves on when the next one is empty or moving too
  assign adv_o = !o_valid_q || out_ready_i;
  assign adv_c = !c_valid_q || adv_o;
  assign adv_b = !b_valid_q || adv_c;
  assign adv_a = !a_valid_q || adv_b;

  assign in_ready_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (adv_a) a_valid_q <= in_valid_i;
      if (adv_b) b_valid_q <= a_valid_q;
      if (adv_c) c_valid_q <= b_valid_q;
      if (adv_o) o_valid_q <= c_valid_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv_a) begin
      in_q <= in_data_i;
    end
  end

  // errors and gain products; previous errors update only with a real tick
  dpld_err_mul u_err_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (a_valid_q && adv_b),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .prod_o (prod)
  );

  // integrators and pid sums
  dpld_integ #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_integ (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (b_valid_q && adv_c),
    .prod_i (prod),
    .sums_o (sums)
  );

  // motor mix into the result register
  dpld_motor #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_motor (
    .clk_i   (clk_i),
    .en_i    (c_valid_q && adv_o),
    .sums_i  (sums),
    .drive_o (out_data_o)
  );

  assign out_valid_o = o_valid_q;

endmodule

### hdl/dpld_chk.sv
// port checker for the dual pid drive core and its bind
module dpld_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dpld_pkg::out_item_t out_data_o
);

  // ticks taken in whose results have not yet gone out
  logic [2:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // result stays offered while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // no result without a tick in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result offered with no tick in flight");

  // the pipeline holds at most four ticks
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more ticks in flight than pipeline stages");

  // with the output side draining, a full pipeline still takes input
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output side ready");

endmodule

bind dual_pid_line_follow_drive_core dpld_chk u_dpld_chk (.*);

### tb/sv/dual_pid_line_follow_drive_core_test.sv
// self-checking regression for the dual pid line-follow drive core
`timescale 1ns / 100ps

module dual_pid_line_follow_drive_core_test;
  import dpld_pkg::*;

  localparam int GAIN_FRAC   = DEF_GAIN_FRAC_BITS;
  // longest quiet stretch allowed on both channels before the run is called hung:
  // it outlasts the long receiver hold-off together with the random gaps and stalls
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_TICKS = 100;

  // tracks the controller state and holds the motor drives still owed by the block
  class drive_scoreboard;
    cfg_t      cfg = CFG_RESET;
    longint    steer_acc;
    longint    speed_acc;
    int        prev_steer_err[2];
    int        prev_speed_err[2];
    out_item_t pending_drives[$];
    int        mismatches;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_TARGET: cfg.line_target = data[6:0];
        REG_STEER_KP:    cfg.steer_kp = data;
        REG_STEER_KI:    cfg.steer_ki = data;
        REG_STEER_KD:    cfg.steer_kd = data;
        REG_SPEED_KP:    cfg.speed_kp = data;
        REG_SPEED_KI:    cfg.speed_ki = data;
        REG_SPEED_KD:    cfg.speed_kd = data;
        REG_FAST_MODE:   cfg.fast_mode = data[0];
        default: ;
      endcase
    endfunction

    // integrator add with the top clamp in whole units and a floor at the int32 minimum
    function longint clamp_acc(longint acc, longint add, int top_units);
      longint s;
      s = acc + add;
      if (s > (longint'(top_units) <<< GAIN_FRAC)) s = longint'(top_units) <<< GAIN_FRAC;
      if (s < -(longint'(1) <<< 31)) s = -(longint'(1) <<< 31);
      return s;
    endfunction

    function logic [15:0] motor_level(longint v);
      longint whole;
      if (v < 0) return 16'h0000;
      whole = v >>> GAIN_FRAC;
      if (whole > 65535) return 16'hFFFF;
      return whole[15:0];
    endfunction

    function out_item_t predict_drives(in_item_t t);
      int        m;
      int        se;
      int        sd;
      int        ve;
      int        vd;
      int        meas;
      longint    steer_sum;
      longint    speed_sum;
      out_item_t d;
      m  = int'(cfg.fast_mode);
      se = int'(t.line_position) - int'(cfg.line_target);
      sd = se - prev_steer_err[m];
      if (m != 0) sd = sd * FAST_DERIV_SCALE;
      prev_steer_err[m] = se;
      meas = int'(t.left_encoder_count) + int'(t.right_encoder_count);
      if (m == 0) meas = meas / 2;
      ve = ((m != 0) ? FAST_SPEED_TARGET : SLOW_SPEED_TARGET) - meas;
      vd = ve - prev_speed_err[m];
      prev_speed_err[m] = ve;
      steer_acc = clamp_acc(steer_acc, longint'(cfg.steer_ki) * se, STEER_INT_TOP);
      speed_acc = clamp_acc(speed_acc, longint'(cfg.speed_ki) * ve, SPEED_INT_TOP);
      steer_sum = longint'(cfg.steer_kp) * se + steer_acc + longint'(cfg.steer_kd) * sd;
      speed_sum = longint'(cfg.speed_kp) * ve + speed_acc + longint'(cfg.speed_kd) * vd;
      d.left_motor_drive  = motor_level(speed_sum + steer_sum);
      d.right_motor_drive = motor_level(speed_sum - steer_sum);
      return d;
    endfunction

    function void note_tick(in_item_t t);
      pending_drives.push_back(predict_drives(t));
    endfunction

    function void check_drives(out_item_t got);
      out_item_t want;
      if (pending_drives.size() == 0) begin
        mismatches++;
        $error("motor drive transfer with no tick pending: left %0d right %0d",
               got.left_motor_drive, got.right_motor_drive);
        return;
      end
      want = pending_drives.pop_front();
      if (got.left_motor_drive !== want.left_motor_drive) begin
        mismatches++;
        $error("left_motor_drive: expected %0d, got %0d",
               want.left_motor_drive, got.left_motor_drive);
      end
      if (got.right_motor_drive !== want.right_motor_drive) begin
        mismatches++;
        $error("right_motor_drive: expected %0d, got %0d",
               want.right_motor_drive, got.right_motor_drive);
      end
    endfunction
  endclass

  // every input starts at a known value
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  drive_scoreboard sb = new;

  // idling control: calm stretches drop all gaps on that side, hold_req asks the
  // receiver for one long hold-off so the pipeline fills and backs up the input
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  bit hold_req      = 1'b0;
  int ticks_sent    = 0;

  dual_pid_line_follow_drive_core #(
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // offer one control tick after a random gap; valid stays up across back-to-back
  // ticks, and the tick is handed to the scoreboard at the edge that takes it
  task automatic send_tick(in_item_t t);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(t);
    ticks_sent++;
    if (ticks_sent % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
  endtask

  // stop offering and wait until every owed drive has come back: the block is idle then
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    while (sb.pending_drives.size() != 0) @(posedge clk_i);
  endtask

  // write all eight registers, one per cycle; unused upper data bits carry junk
  task automatic load_settings(cfg_t c);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] word;
    for (int r = 0; r < 8; r++) begin
      idx = r[CFG_IDX_W-1:0];
      case (idx)
        REG_LINE_TARGET: word = {9'($urandom), c.line_target};
        REG_STEER_KP:    word = c.steer_kp;
        REG_STEER_KI:    word = c.steer_ki;
        REG_STEER_KD:    word = c.steer_kd;
        REG_SPEED_KP:    word = c.speed_kp;
        REG_SPEED_KI:    word = c.speed_ki;
        REG_SPEED_KD:    word = c.speed_kd;
        default:         word = {15'($urandom), c.fast_mode};
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= word;
      @(posedge clk_i);
      sb.write_reg(idx, word);
    end
    cfg_we_i <= 1'b0;
  endtask

  // gains lean small so the drives often land inside the range, with full-scale mixed in
  function automatic logic [15:0] pick_gain();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2048));
  endfunction

  // the first phases sit on the corners of the settings, the rest are random
  function automatic cfg_t pick_settings(int phase);
    cfg_t c;
    case (phase)
      0: c = '{7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
      1: c = '{7'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0};
      2: c = '{7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
      3: c = '{7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1};
      default: begin
        c.line_target = 7'($urandom_range(0, 127));
        c.steer_kp    = pick_gain();
        c.steer_ki    = pick_gain();
        c.steer_kd    = pick_gain();
        c.speed_kp    = pick_gain();
        c.speed_ki    = pick_gain();
        c.speed_kd    = pick_gain();
        c.fast_mode   = 1'($urandom_range(0, 1));
      end
    endcase
    return c;
  endfunction

  // tick mix: plain noise, steady cruising near the targets (the case that keeps the
  // drives out of saturation), field corners, hard forward or reverse wheel speed,
  // and the line at either edge of the sensor
  function automatic in_item_t make_tick(int target);
    in_item_t    t;
    int          pos;
    logic [15:0] corner[4];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    t.line_position       = 7'($urandom);
    t.left_encoder_count  = 16'($urandom);
    t.right_encoder_count = 16'($urandom);
    case ($urandom_range(0, 9))
      3, 4, 5: begin
        pos = target + int'($urandom_range(0, 40)) - 20;
        if (pos < 0) pos = 0;
        if (pos > 127) pos = 127;
        t.line_position       = 7'(pos);
        t.left_encoder_count  = 16'(int'($urandom_range(0, 50)) - 10);
        t.right_encoder_count = 16'(int'($urandom_range(0, 50)) - 10);
      end
      6: begin
        t.left_encoder_count  = corner[$urandom_range(0, 3)];
        t.right_encoder_count = corner[$urandom_range(0, 3)];
      end
      7: begin
        t.left_encoder_count  = 16'($urandom_range(20000, 32767));
        t.right_encoder_count = 16'($urandom_range(20000, 32767));
      end
      8: begin
        t.left_encoder_count  = 16'(-int'($urandom_range(20000, 32768)));
        t.right_encoder_count = 16'(-int'($urandom_range(20000, 32768)));
      end
      9: begin
        t.line_position       = ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd0;
        t.left_encoder_count  = 16'(int'($urandom_range(0, 60)) - 30);
        t.right_encoder_count = 16'(int'($urandom_range(0, 60)) - 30);
      end
      default: ;
    endcase
    return t;
  endfunction

  // receiving side: random stall before each result, calm stretches, and one long
  // hold-off on request, counted here while the sender keeps offering ticks
  initial begin : drive_sink
    int stall;
    int drives_seen;
    drives_seen = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = receiver_calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_drives(out_data_o);
      drives_seen++;
      if (drives_seen % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // hang detector: any transfer on either channel resets the quiet count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("dual_pid_line_follow_drive_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    in_item_t fast_corners[12];
    in_item_t slow_corners[10];
    cfg_t     slow_trial;

    // fast mode with the reset settings: standing, exact speed target, encoder
    // extremes with wrap-free sums, one-off line errors on both sides
    fast_corners = '{
      '{7'd64,  16'h0000, 16'h0000},
      '{7'd64,  16'h0014, 16'h0014},
      '{7'd0,   16'h8000, 16'h8000},
      '{7'd127, 16'h7FFF, 16'h7FFF},
      '{7'd0,   16'h7FFF, 16'h8000},
      '{7'd127, 16'h8000, 16'h7FFF},
      '{7'd63,  16'hFFFF, 16'h0000},
      '{7'd65,  16'h0000, 16'hFFFF},
      '{7'd127, 16'h0000, 16'h0000},
      '{7'd0,   16'h0000, 16'h0000},
      '{7'd100, 16'h0015, 16'h0014},
      '{7'd30,  16'h0013, 16'h0014}
    };
    // slow mode: odd sums that truncate toward zero from both signs, the largest
    // magnitudes, and the exact slow target
    slow_corners = '{
      '{7'd64,  16'hFFFF, 16'hFFFE},
      '{7'd64,  16'h0001, 16'h0002},
      '{7'd64,  16'h8000, 16'h8001},
      '{7'd64,  16'h7FFF, 16'h7FFE},
      '{7'd0,   16'hFFFB, 16'h0004},
      '{7'd127, 16'h0003, 16'h0004},
      '{7'd127, 16'h0005, 16'h0005},
      '{7'd127, 16'h000A, 16'h000B},
      '{7'd0,   16'h8000, 16'h8000},
      '{7'd0,   16'h7FFF, 16'h7FFF}
    };
    // unit gains with full integral gains: the steering integrator runs into its top clamp
    // and the speed integrator is driven toward its floor
    slow_trial = '{7'd64, 16'd256, 16'hFFFF, 16'd256, 16'd256, 16'hFFFF, 16'd256, 1'b0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (fast_corners[k]) send_tick(fast_corners[k]);
    drain_ticks();
    load_settings(slow_trial);
    foreach (slow_corners[k]) send_tick(slow_corners[k]);
    drain_ticks();

    // random phases, each under its own settings written while the block is idle
    for (int p = 0; p < PHASES; p++) begin
      load_settings(pick_settings(p));
      if (p == 4) hold_req = 1'b1;
      repeat (PHASE_TICKS) send_tick(make_tick(int'(sb.cfg.line_target)));
      drain_ticks();
    end

    // keep the clock running so any stray transfer shows up
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_drives.size() == 0) begin
      $display("dual_pid_line_follow_drive_core regression: pass");
    end else begin
      $display("dual_pid_line_follow_drive_core regression: fail");
    end
    $finish;
  end

endmodule
